/* design/p2spi_pkg.sv */
// Shared types and constants for the parallel-port to SPI bridge.
// Holds the phase encoding, event codes and control command codes. No dependencies.
`timescale 1ns / 1ps

package p2spi_pkg;

  // Width of the transfer byte counter.
  localparam int COUNT_BITS = 13;

  // Widths of the stream payloads; the tdata widths are rounded up to whole bytes.
  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 24;

  // Event codes carried on the input tuser.
  localparam logic [2:0] EV_REQ_ASSERT  = 3'd0;
  localparam logic [2:0] EV_REQ_RELEASE = 3'd1;
  localparam logic [2:0] EV_CLK_TOGGLE  = 3'd2;
  localparam logic [2:0] EV_CARD_CHANGE = 3'd3;
  localparam logic [2:0] EV_SPI_DONE    = 3'd4;

  // Control command codes, taken from bits 5:1 of the command byte.
  localparam logic [4:0] CTL_SELECT = 5'd0;
  localparam logic [4:0] CTL_CARD   = 5'd1;
  localparam logic [4:0] CTL_SPEED  = 5'd2;

  // Byte sent on MOSI while reading.
  localparam logic [7:0] SPI_FILL = 8'hff;

  // Command phase, one-hot.
  typedef enum logic [8:0] {
    PH_IDLE       = 9'b0_0000_0001,
    PH_SECOND     = 9'b0_0000_0010,
    PH_CARD       = 9'b0_0000_0100,
    PH_READ       = 9'b0_0000_1000,
    PH_READ_EARLY = 9'b0_0001_0000,
    PH_WRITE_CLK  = 9'b0_0010_0000,
    PH_WRITE_SPI  = 9'b0_0100_0000,
    PH_DONE       = 9'b0_1000_0000,
    PH_HALT       = 9'b1_0000_0000
  } phase_t;

endpackage

/* design/parallel_to_spi_bridge.sv */
// Parallel-port to SPI bridge: top level with the command decoder and result register.
// Depends on p2spi_pkg for the phase type, event codes and counter width.
`timescale 1ns / 1ps

// One request on the input stream is one event on the host or SPI side (REQ assert or
// release, CLK toggle, card change, end of an SPI byte exchange); each produces exactly
// one result request with the host port levels and an optional SPI exchange start.
// An event is decoded against the command state combinationally and its result is
// loaded into the output register, so a new event is taken every cycle; the only limit
// is the one-deep output register, which is refilled in the cycle it is drained.
// There is no reset sweep: the block accepts events as soon as reset is released.
module parallel_to_spi_bridge
  import p2spi_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [7:0] par_data, [15:8] miso_byte, [16] card_det, [23:17] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [2:0] cmd
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [0] act, [1] irq, [2] chip_select, [3] spi_fast, [4] drive_data,
  // [12:5] data_out, [13] spi_start, [21:14] spi_tx, [23:22] zero
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  // Command state.
  phase_t                phase_r, phase_nxt;
  logic [COUNT_BITS-1:0] remaining_r, remaining_nxt;
  logic                  read_mode_r, read_mode_nxt;
  logic [7:0]            next_byte_r, next_byte_nxt;
  logic                  byte_ready_r, byte_ready_nxt;
  logic                  select_r, select_nxt;
  logic                  fast_r, fast_nxt;
  logic                  irq_r, irq_nxt;
  logic                  irq_enable_r, irq_enable_nxt;
  logic                  irq_pending_r, irq_pending_nxt;
  logic                  drive_r, drive_nxt;
  logic [7:0]            out_byte_r, out_byte_nxt;

  // Result register.
  logic                   out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;

  logic       in_acc;
  logic [2:0] cmd;
  logic [7:0] par_data;
  logic [7:0] miso_byte;
  logic       card_det;
  logic [4:0] ctl_code;
  logic       spi_start;
  logic [7:0] spi_tx;
  logic       act;

  assign cmd          = in_tuser[2:0];
  assign par_data     = in_tdata[7:0];
  assign miso_byte    = in_tdata[15:8];
  assign card_det     = in_tdata[16];
  assign ctl_code     = par_data[5:1];

  // A new request is taken whenever the result register is free or being drained.
  assign in_tready = !out_tvalid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  // Event decode against the current phase.
  always_comb begin
    phase_nxt       = phase_r;
    remaining_nxt   = remaining_r;
    read_mode_nxt   = read_mode_r;
    next_byte_nxt   = next_byte_r;
    byte_ready_nxt  = byte_ready_r;
    select_nxt      = select_r;
    fast_nxt        = fast_r;
    irq_nxt         = irq_r;
    irq_enable_nxt  = irq_enable_r;
    irq_pending_nxt = irq_pending_r;
    drive_nxt       = drive_r;
    out_byte_nxt    = out_byte_r;
    spi_start       = 1'b0;
    spi_tx          = 8'h00;

    case (cmd)
      EV_REQ_ASSERT: begin
        irq_enable_nxt = 1'b0;
        if (!par_data[7]) begin
          // Short transfer, count in the low six bits.
          remaining_nxt  = COUNT_BITS'(par_data[5:0]);
          byte_ready_nxt = 1'b0;
          if (par_data[6]) begin
            read_mode_nxt = 1'b1;
            drive_nxt     = 1'b1;
            out_byte_nxt  = par_data;
            phase_nxt     = PH_READ;
            spi_start     = 1'b1;
            spi_tx        = SPI_FILL;
          end else begin
            read_mode_nxt = 1'b0;
            phase_nxt     = PH_WRITE_CLK;
          end
        end else if (!par_data[6]) begin
          // Long transfer: the high count bits now, the rest with the next toggle.
          remaining_nxt = COUNT_BITS'({par_data[5:0], 7'b0000000});
          phase_nxt     = PH_SECOND;
        end else begin
          case (ctl_code)
            CTL_SELECT: begin
              select_nxt = par_data[0];
              phase_nxt  = PH_DONE;
            end
            CTL_CARD: begin
              irq_nxt   = 1'b0;
              phase_nxt = PH_CARD;
            end
            CTL_SPEED: begin
              fast_nxt  = par_data[0];
              phase_nxt = PH_DONE;
            end
            default: begin
              phase_nxt = PH_HALT;
            end
          endcase
        end
      end

      EV_REQ_RELEASE: begin
        phase_nxt      = PH_IDLE;
        drive_nxt      = 1'b0;
        out_byte_nxt   = 8'h00;
        byte_ready_nxt = 1'b0;
        irq_enable_nxt = 1'b1;
        if (irq_pending_r) begin
          irq_pending_nxt = 1'b0;
          irq_nxt         = 1'b1;
        end
      end

      EV_CLK_TOGGLE: begin
        case (phase_r)
          PH_SECOND: begin
            remaining_nxt  = remaining_r | COUNT_BITS'(par_data[6:0]);
            byte_ready_nxt = 1'b0;
            if (par_data[7]) begin
              read_mode_nxt = 1'b1;
              drive_nxt     = 1'b1;
              out_byte_nxt  = par_data;
              phase_nxt     = PH_READ;
              spi_start     = 1'b1;
              spi_tx        = SPI_FILL;
            end else begin
              read_mode_nxt = 1'b0;
              phase_nxt     = PH_WRITE_CLK;
            end
          end
          PH_CARD: begin
            drive_nxt    = 1'b1;
            out_byte_nxt = {7'b0000000, card_det};
            phase_nxt    = PH_DONE;
          end
          PH_READ: begin
            if (byte_ready_r) begin
              // Present the received byte and start the next exchange if any remain.
              out_byte_nxt   = next_byte_r;
              drive_nxt      = 1'b1;
              byte_ready_nxt = 1'b0;
              if (remaining_r != '0) begin
                remaining_nxt = remaining_r - COUNT_BITS'(1);
                phase_nxt     = PH_READ;
                spi_start     = 1'b1;
                spi_tx        = SPI_FILL;
              end else begin
                phase_nxt = PH_DONE;
              end
            end else begin
              phase_nxt = PH_READ_EARLY;
            end
          end
          PH_READ_EARLY: begin
            phase_nxt = PH_READ;
          end
          PH_WRITE_CLK: begin
            phase_nxt = PH_WRITE_SPI;
            spi_start = 1'b1;
            spi_tx    = par_data;
          end
          PH_WRITE_SPI: begin
            // An early toggle latches the byte; a second one cancels it.
            if (byte_ready_r) begin
              byte_ready_nxt = 1'b0;
            end else begin
              byte_ready_nxt = 1'b1;
              next_byte_nxt  = par_data;
            end
          end
          default: begin
          end
        endcase
      end

      EV_CARD_CHANGE: begin
        if (irq_enable_r) begin
          irq_nxt = 1'b1;
        end else begin
          irq_pending_nxt = 1'b1;
        end
      end

      EV_SPI_DONE: begin
        case (phase_r)
          PH_READ: begin
            if (!byte_ready_r) begin
              next_byte_nxt  = miso_byte;
              byte_ready_nxt = 1'b1;
            end
          end
          PH_READ_EARLY: begin
            // The toggle came first, so the byte goes straight to the host.
            next_byte_nxt  = miso_byte;
            out_byte_nxt   = miso_byte;
            drive_nxt      = 1'b1;
            byte_ready_nxt = 1'b0;
            if (remaining_r != '0) begin
              remaining_nxt = remaining_r - COUNT_BITS'(1);
              phase_nxt     = PH_READ;
              spi_start     = 1'b1;
              spi_tx        = SPI_FILL;
            end else begin
              phase_nxt = PH_DONE;
            end
          end
          PH_WRITE_SPI: begin
            if (remaining_r == '0) begin
              byte_ready_nxt = 1'b0;
              phase_nxt      = PH_DONE;
            end else begin
              remaining_nxt = remaining_r - COUNT_BITS'(1);
              if (byte_ready_r) begin
                byte_ready_nxt = 1'b0;
                spi_start      = 1'b1;
                spi_tx         = next_byte_r;
              end else begin
                phase_nxt = PH_WRITE_CLK;
              end
            end
          end
          default: begin
          end
        endcase
      end

      default: begin
      end
    endcase
  end

  // Result assembly from the updated state.
  assign act = (phase_nxt != PH_IDLE) && (phase_nxt != PH_HALT);

  always_comb begin
    out_tdata_nxt = {2'b00, spi_tx, spi_start, out_byte_nxt, drive_nxt, fast_nxt,
                     select_nxt, irq_nxt, act};
    if (in_acc) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end else begin
      out_tvalid_nxt = out_tvalid_r;
    end
  end

  // Command state, updated once per accepted request; the result valid flag is updated every cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      remaining_r   <= '0;
      read_mode_r   <= 1'b0;
      next_byte_r   <= 8'h00;
      byte_ready_r  <= 1'b0;
      select_r      <= 1'b0;
      fast_r        <= 1'b0;
      irq_r         <= 1'b0;
      irq_enable_r  <= 1'b1;
      irq_pending_r <= 1'b0;
      drive_r       <= 1'b0;
      out_byte_r    <= 8'h00;
      out_tvalid_r  <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
      if (in_acc) begin
        phase_r       <= phase_nxt;
        remaining_r   <= remaining_nxt;
        read_mode_r   <= read_mode_nxt;
        next_byte_r   <= next_byte_nxt;
        byte_ready_r  <= byte_ready_nxt;
        select_r      <= select_nxt;
        fast_r        <= fast_nxt;
        irq_r         <= irq_nxt;
        irq_enable_r  <= irq_enable_nxt;
        irq_pending_r <= irq_pending_nxt;
        drive_r       <= drive_nxt;
        out_byte_r    <= out_byte_nxt;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_tdata_r <= out_tdata_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // Checks on the decoder and result register.
  a_tx_zero_when_idle : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && !out_tdata_r[13]) |-> (out_tdata_r[21:14] == 8'h00))
    else $error("spi_tx not zero without an exchange start");

  a_release_to_idle : assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (cmd == EV_REQ_RELEASE)) |=> (phase_r == PH_IDLE && !drive_r))
    else $error("REQ release did not return to idle");

  a_read_mode_in_read : assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_READ || phase_r == PH_READ_EARLY) |-> read_mode_r)
    else $error("read phase without read mode");

  a_irq_masked_in_cmd : assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_IDLE) |-> !irq_enable_r)
    else $error("card-change interrupt enabled while a command runs");

endmodule
